@@ src/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, types and command codes of the go-back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned WINDOW      = 4;
  localparam int unsigned QUEUE_DEPTH = 16;

  // the window can never reach past the end of the queue
  localparam int unsigned SPAN_MAX = (WINDOW < QUEUE_DEPTH) ? WINDOW : QUEUE_DEPTH;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned LEN_W    = 11;

  localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned KW      = $clog2(SPAN_MAX + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_ACK     = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } entry_t;

endpackage

@@ src/gbn_in_if.sv @@
// ----------------------------------------------------------------------------
// gbn_in_if
// Command channel of the sender window: valid/ready with command payload.
// ----------------------------------------------------------------------------
interface gbn_in_if;
  import gbn_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SEQ_W-1:0]    seq_num;
  logic [HANDLE_W-1:0] frame_handle;
  logic [LEN_W-1:0]    frame_len;

  modport source (output valid, output cmd, output seq_num, output frame_handle,
                  output frame_len, input ready);
  modport sink   (input valid, input cmd, input seq_num, input frame_handle,
                  input frame_len, output ready);
endinterface

@@ src/gbn_out_if.sv @@
// ----------------------------------------------------------------------------
// gbn_out_if
// Transmit channel of the sender window: valid/ready with frame descriptor.
// ----------------------------------------------------------------------------
interface gbn_out_if;
  import gbn_pkg::*;

  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] tx_handle;
  logic [LEN_W-1:0]    tx_len;
  logic [SEQ_W-1:0]    tx_seq;
  logic                is_last;
  logic                dropped;

  modport source (output valid, output tx_handle, output tx_len, output tx_seq,
                  output is_last, output dropped, input ready);
  modport sink   (input valid, input tx_handle, input tx_len, input tx_seq,
                  input is_last, input dropped, output ready);
endinterface

@@ src/gbn_cell.sv @@
// ----------------------------------------------------------------------------
// gbn_cell
// One slot of the pending-frame chain: loads a new frame or takes its
// neighbor's frame when the chain advances toward the head.
// ----------------------------------------------------------------------------
module gbn_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  gbn_pkg::entry_t load_data_i,
  input  gbn_pkg::entry_t next_i,
  output gbn_pkg::entry_t data_o
);
  import gbn_pkg::*;

  entry_t data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ src/go_back_n_arq_sender.sv @@
// ----------------------------------------------------------------------------
// go_back_n_arq_sender
// Go-back-N sender window over a chain of pending-frame cells.
// ----------------------------------------------------------------------------
// Pending frames sit in a row of cells with the oldest frame always in the
// first cell; retiring a frame moves the whole row one cell toward the head.
// Commands are taken one at a time. A timeout resends every frame in the
// window from the head. An acknowledgement first retires the frames up to
// its match, the chain advancing one cell per cycle, and then admits further
// frames into the window. Result beats wait on the transmit channel while
// the sink holds ready low.
// The ack search compares all window cells against the ack number at once.
module go_back_n_arq_sender (
  input  logic     clk_i,
  input  logic     rst_ni,
  gbn_in_if.sink   in_i,
  gbn_out_if.source out_o
);
  import gbn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RETIRE,
    ST_ADMIT,
    ST_EMIT
  } state_e;

  state_e               state_q;
  cmd_e                 cmd_q;
  logic [SEQ_W-1:0]     seq_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [LEN_W-1:0]     len_q;
  logic [COUNT_W-1:0]   count_q;
  logic [KW-1:0]        in_flight_q;
  logic [KW-1:0]        k_q;
  logic [KW-1:0]        end_q;
  logic [KW-1:0]        ret_q;
  logic                 adv_q;

  logic                 out_valid_q;
  logic [HANDLE_W-1:0]  tx_handle_q;
  logic [LEN_W-1:0]     tx_len_q;
  logic [SEQ_W-1:0]     tx_seq_q;
  logic                 is_last_q;
  logic                 dropped_q;

  entry_t               cell_data [QUEUE_DEPTH];
  entry_t               new_entry;
  entry_t               emit_entry;
  logic                 load_en;
  logic                 shift_en;
  logic                 out_free;
  logic                 out_load;
  logic                 full;
  logic [COUNT_W-1:0]   span_c;
  logic [KW-1:0]        span_k;
  logic [KW-1:0]        k_next;
  logic                 hit_any;
  logic [KW-1:0]        hit_ret;

  assign out_free  = !out_valid_q || out_o.ready;
  assign full      = (count_q == COUNT_W'(QUEUE_DEPTH));
  assign span_c    = (count_q < COUNT_W'(SPAN_MAX)) ? count_q : COUNT_W'(SPAN_MAX);
  assign span_k    = KW'(span_c);
  assign k_next    = k_q + KW'(1);
  assign new_entry = '{seq: seq_q, handle: handle_q, len: len_q};
  assign emit_entry = cell_data[IDX_W'(k_q)];

  assign load_en  = (state_q == ST_EXEC) && (cmd_q == CMD_SEND) && out_free && !full;
  assign shift_en = (state_q == ST_RETIRE);

  // a new result beat enters the output register this cycle
  assign out_load = out_free &&
                    (((state_q == ST_EXEC) && (cmd_q == CMD_SEND) &&
                      (full || (in_flight_q < KW'(SPAN_MAX)))) ||
                     (state_q == ST_EMIT));

  // chain of pending-frame cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t next_data;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_data = cell_data[i];
    end else begin : g_body
      assign next_data = cell_data[i+1];
    end
    gbn_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (load_en && (count_q[IDX_W-1:0] == IDX_W'(i))),
      .shift_i    (shift_en),
      .load_data_i(new_entry),
      .next_i     (next_data),
      .data_o     (cell_data[i])
    );
  end

  // oldest window cell holding the ack number wins
  always_comb begin
    hit_any = 1'b0;
    hit_ret = '0;
    for (int j = SPAN_MAX - 1; j >= 0; j--) begin
      if ((KW'(j) < span_k) && (cell_data[j].seq == seq_q)) begin
        hit_any = 1'b1;
        hit_ret = KW'(j + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_SEND;
      count_q     <= '0;
      in_flight_q <= '0;
      k_q         <= '0;
      end_q       <= '0;
      ret_q       <= '0;
      adv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            cmd_q    <= cmd_e'(in_i.cmd);
            seq_q    <= in_i.seq_num;
            handle_q <= in_i.frame_handle;
            len_q    <= in_i.frame_len;
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (cmd_q)
            CMD_SEND: begin
              if (out_free) begin
                if (full) begin
                  out_valid_q <= 1'b1;
                  tx_handle_q <= '0;
                  tx_len_q    <= '0;
                  tx_seq_q    <= '0;
                  is_last_q   <= 1'b1;
                  dropped_q   <= 1'b1;
                end else begin
                  count_q <= count_q + COUNT_W'(1);
                  if (in_flight_q < KW'(SPAN_MAX)) begin
                    in_flight_q <= in_flight_q + KW'(1);
                    out_valid_q <= 1'b1;
                    tx_handle_q <= handle_q;
                    tx_len_q    <= len_q;
                    tx_seq_q    <= seq_q;
                    is_last_q   <= 1'b1;
                    dropped_q   <= 1'b0;
                  end
                end
                state_q <= ST_IDLE;
              end
            end
            CMD_TIMEOUT: begin
              k_q     <= '0;
              end_q   <= span_k;
              adv_q   <= 1'b0;
              state_q <= (span_k == '0) ? ST_IDLE : ST_EMIT;
            end
            CMD_ACK: begin
              if (hit_any) begin
                ret_q   <= hit_ret;
                state_q <= ST_RETIRE;
              end else begin
                state_q <= ST_ADMIT;
              end
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_RETIRE: begin
          count_q <= count_q - COUNT_W'(1);
          if (in_flight_q != '0) begin
            in_flight_q <= in_flight_q - KW'(1);
          end
          ret_q <= ret_q - KW'(1);
          if (ret_q == KW'(1)) begin
            state_q <= ST_ADMIT;
          end
        end
        ST_ADMIT: begin
          k_q     <= in_flight_q;
          end_q   <= span_k;
          adv_q   <= 1'b1;
          state_q <= (in_flight_q < span_k) ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            tx_handle_q <= emit_entry.handle;
            tx_len_q    <= emit_entry.len;
            tx_seq_q    <= emit_entry.seq;
            is_last_q   <= (k_next == end_q);
            dropped_q   <= 1'b0;
            k_q         <= k_next;
            if (adv_q) begin
              in_flight_q <= in_flight_q + KW'(1);
            end
            if (k_next == end_q) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.tx_handle = tx_handle_q;
  assign out_o.tx_len    = tx_len_q;
  assign out_o.tx_seq    = tx_seq_q;
  assign out_o.is_last   = is_last_q;
  assign out_o.dropped   = dropped_q;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the go-back-N sender window. A scoreboard object
// mirrors the pending-frame queue and the in-flight count, predicts every
// transmit beat of each accepted command and checks the beats in order,
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import gbn_pkg::*;

  localparam int unsigned        CLK_PERIOD   = 4;
  localparam int unsigned        HOLD_CYCLES  = 80;
  localparam int unsigned        DRAIN_CYCLES = 32;
  localparam int unsigned        RANDOM_ITEMS = 360;
  localparam int unsigned        QUIET_FROM   = 300;
  localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic [SEQ_W-1:0]    seq;
    logic                is_last;
    logic                dropped;
  } tx_beat_t;

  class gbn_scoreboard;
    entry_t      frames[$];
    int unsigned in_flight;
    tx_beat_t    tx_expected[$];
    int unsigned failures;

    function int unsigned window_span();
      return (frames.size() < WINDOW) ? frames.size() : WINDOW;
    endfunction

    function tx_beat_t beat_of(entry_t e);
      tx_beat_t b;
      b         = '0;
      b.handle  = e.handle;
      b.len     = e.len;
      b.seq     = e.seq;
      return b;
    endfunction

    // accepted command: update the queue copy and queue up its transmit beats
    function void note_command(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                               input logic [HANDLE_W-1:0] handle,
                               input logic [LEN_W-1:0] len);
      tx_beat_t    burst[$];
      tx_beat_t    b;
      entry_t      e;
      int unsigned span;
      int unsigned hit;
      span = window_span();
      case (cmd)
        CMD_SEND: begin
          if (frames.size() >= QUEUE_DEPTH) begin
            b         = '0;
            b.dropped = 1'b1;
            burst.insert(burst.size(), b);
          end else begin
            e.seq    = seq;
            e.handle = handle;
            e.len    = len;
            frames.insert(frames.size(), e);
            if (in_flight < WINDOW) begin
              burst.insert(burst.size(), beat_of(e));
              in_flight++;
            end
          end
        end
        CMD_TIMEOUT: begin
          for (int k = 0; k < span; k++) burst.insert(burst.size(), beat_of(frames[k]));
        end
        CMD_ACK: begin
          hit = span;
          for (int k = 0; k < span; k++) begin
            if (hit == span && frames[k].seq == seq) hit = k;
          end
          // a match retires that frame and everything older
          if (hit < span) begin
            repeat (hit + 1) frames.delete(0);
            in_flight = (in_flight > hit + 1) ? in_flight - (hit + 1) : 0;
          end
          while (in_flight < frames.size() && in_flight < WINDOW) begin
            burst.insert(burst.size(), beat_of(frames[in_flight]));
            in_flight++;
          end
        end
        default: ;
      endcase
      if (burst.size() != 0) begin
        b = burst[burst.size() - 1];
        b.is_last = 1'b1;
        burst[burst.size() - 1] = b;
      end
      foreach (burst[k]) tx_expected.insert(tx_expected.size(), burst[k]);
    endfunction

    function void check_beat(tx_beat_t got);
      tx_beat_t want;
      if (tx_expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: handle %h len %h seq %h last %b dropped %b",
                   got.handle, got.len, got.seq, got.is_last, got.dropped);
        return;
      end
      want = tx_expected[0];
      tx_expected.delete(0);
      if (got.handle !== want.handle || got.len !== want.len || got.seq !== want.seq ||
          got.is_last !== want.is_last || got.dropped !== want.dropped) begin
        failures++;
        if (failures <= 10) begin
          $display("beat mismatch: exp handle %h len %h seq %h last %b dropped %b",
                   want.handle, want.len, want.seq, want.is_last, want.dropped);
          $display("               got handle %h len %h seq %h last %b dropped %b",
                   got.handle, got.len, got.seq, got.is_last, got.dropped);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  gbn_in_if  in_if ();
  gbn_out_if out_if ();

  go_back_n_arq_sender dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  gbn_scoreboard board = new();

  bit               quiet_run;
  bit               hold_pending;
  logic [SEQ_W-1:0] next_seq;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    #(500_000);
    $display("simulation failed");
    $finish;
  end

  // transmit channel: random stalls, one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet_run && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_beat({out_if.tx_handle, out_if.tx_len, out_if.tx_seq,
                        out_if.is_last, out_if.dropped});
  end

  // present one command beat, wait for it to be taken, maybe idle afterwards
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                       input logic [HANDLE_W-1:0] handle, input logic [LEN_W-1:0] len);
    in_if.valid        <= 1'b1;
    in_if.cmd          <= cmd;
    in_if.seq_num      <= seq;
    in_if.frame_handle <= handle;
    in_if.frame_len    <= len;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_command(cmd, seq, handle, len);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic send_frame();
    logic [SEQ_W-1:0] seq;
    seq = next_seq;
    // now and then reuse a queued sequence number so acks see duplicates
    if (board.frames.size() != 0 && $urandom_range(0, 19) == 0)
      seq = board.frames[$urandom_range(0, board.frames.size() - 1)].seq;
    else
      next_seq++;
    issue(CMD_SEND, seq, HANDLE_W'($urandom), LEN_W'($urandom));
  endtask

  task automatic ack_window();
    int unsigned span;
    logic [SEQ_W-1:0] seq;
    span = board.window_span();
    seq  = (span == 0) ? SEQ_W'($urandom) : board.frames[$urandom_range(0, span - 1)].seq;
    issue(CMD_ACK, seq, HANDLE_W'($urandom), LEN_W'($urandom));
  endtask

  // stray acks and the unused command code
  task automatic noise_item();
    int unsigned size;
    logic [SEQ_W-1:0] seq;
    size = board.frames.size();
    case ($urandom_range(0, 2))
      0: issue(CMD_UNUSED, SEQ_W'($urandom), HANDLE_W'($urandom), LEN_W'($urandom));
      1: begin
        seq = (size > WINDOW) ? board.frames[$urandom_range(WINDOW, size - 1)].seq
                              : next_seq + SEQ_W'($urandom_range(1, 1000));
        issue(CMD_ACK, seq, HANDLE_W'($urandom), LEN_W'($urandom));
      end
      default: issue(CMD_ACK, SEQ_W'($urandom), HANDLE_W'($urandom), LEN_W'($urandom));
    endcase
  endtask

  initial begin
    int unsigned r;
    bit          fill_phase;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.cmd          <= CMD_SEND;
    in_if.seq_num      <= '0;
    in_if.frame_handle <= '0;
    in_if.frame_len    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(CMD_TIMEOUT, 32'h1234_5678, 8'h5A, 11'h2A5);   // nothing queued yet
    issue(CMD_UNUSED, '1, '1, '1);
    issue(CMD_SEND, 32'h0000_0000, 8'h00, 11'h000);
    issue(CMD_SEND, 32'hFFFF_FFFF, 8'hFF, 11'h7FF);
    issue(CMD_SEND, 32'h0000_0010, 8'hA5, 11'h555);
    issue(CMD_SEND, 32'h0000_0011, 8'h5A, 11'h2AA);
    issue(CMD_SEND, 32'h0000_0012, 8'h3C, 11'h0F0);      // window full, held back
    issue(CMD_TIMEOUT, 32'hFFFF_FFFF, 8'hFF, 11'h7FF);
    issue(CMD_ACK, 32'hDEAD_BEEF, 8'h00, 11'h000);       // no match
    issue(CMD_ACK, 32'h0000_0012, 8'h00, 11'h000);       // queued but outside window
    issue(CMD_ACK, 32'hFFFF_FFFF, 8'h00, 11'h000);       // retires two, admits one
    for (int k = 0; k < 13; k++)
      issue(CMD_SEND, 32'h0000_0100 + k, HANDLE_W'($urandom), LEN_W'($urandom));
    issue(CMD_SEND, 32'h0000_0200, 8'hC3, 11'h3C3);      // queue full, dropped
    issue(CMD_ACK, 32'h0000_0100, 8'h00, 11'h000);       // retires whole window

    // sequence numbers wrap early in the random part
    next_seq = 32'hFFFF_FFF8;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      fill_phase = ((i / 40) % 2) == 0;
      if (i == 150) hold_pending = 1'b1;
      if (i == QUIET_FROM) quiet_run = 1'b1;
      r = $urandom_range(0, 99);
      if (i >= 150 && i < 180) send_frame();
      else if (r < (fill_phase ? 70 : 40)) send_frame();
      else if (r < 82) ack_window();
      else if (r < 93) issue(CMD_TIMEOUT, SEQ_W'($urandom), HANDLE_W'($urandom),
                             LEN_W'($urandom));
      else noise_item();
    end
    in_if.valid <= 1'b0;

    while (board.tx_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
